// ----- hdl/multi_port_serial_ring_buffers_macros.svh -----
// Assertion macros shared by the ring buffer RTL.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef MULTI_PORT_SERIAL_RING_BUFFERS_MACROS_SVH
`define MULTI_PORT_SERIAL_RING_BUFFERS_MACROS_SVH

// Condition must hold at every edge.
`define MPSRB_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When trig holds, cond must hold in the next cycle.
`define MPSRB_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- hdl/mpsrb_pkg.sv -----
`timescale 1ns / 1ps
package mpsrb_pkg;

   localparam int PORTS_DEF    = 4;
   localparam int RX_DEPTH_DEF = 256;
   localparam int TX_DEPTH_DEF = 128;

   localparam int PORT_W   = 2;
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int RXCNT_W  = 8;
   localparam int TXUSED_W = 7;

   localparam logic [OP_W-1:0] OP_LINE_RX    = 2'd0;
   localparam logic [OP_W-1:0] OP_HOST_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_HOST_WRITE = 2'd2;
   localparam logic [OP_W-1:0] OP_TX_TICK    = 2'd3;

   // memory strobes issued for one request
   typedef struct packed {
      logic rx_we;
      logic rx_re;
      logic tx_we;
      logic tx_re;
   } mem_ctl_type;

   // result fields known at accept time; byte fields come from the rams
   typedef struct packed {
      logic                rd_sel;
      logic [RXCNT_W-1:0]  rx_count;
      logic [TXUSED_W-1:0] tx_used;
      logic                tx_empty;
      logic                tx_valid;
      logic                tx_enabled;
   } pend_type;

endpackage

// ----- hdl/mpsrb_if.sv -----
`timescale 1ns / 1ps
interface mpsrb_req_if import mpsrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [PORT_W-1:0]   port;
   logic [BYTE_W-1:0]   data_in;

   modport source (output valid, output op, output port, output data_in, input ready);
   modport sink   (input valid, input op, input port, input data_in, output ready);
endinterface

interface mpsrb_rsp_if import mpsrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   read_byte;
   logic [RXCNT_W-1:0]  rx_count;
   logic [TXUSED_W-1:0] tx_used;
   logic                tx_empty;
   logic                tx_valid;
   logic [BYTE_W-1:0]   tx_byte;
   logic                tx_enabled;

   modport source (output valid, output read_byte, output rx_count, output tx_used,
                   output tx_empty, output tx_valid, output tx_byte, output tx_enabled,
                   input ready);
   modport sink   (input valid, input read_byte, input rx_count, input tx_used,
                   input tx_empty, input tx_valid, input tx_byte, input tx_enabled,
                   output ready);
endinterface

// ----- hdl/mpsrb_ram.sv -----
`timescale 1ns / 1ps
module mpsrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/mpsrb_ctrl.sv -----
`timescale 1ns / 1ps
module mpsrb_ctrl import mpsrb_pkg::*; #(
   parameter int PORTS    = PORTS_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [OP_W-1:0]                      op,
   input  logic [PORT_W-1:0]                    port,
   output mem_ctl_type                          ctl,
   output logic [$clog2(PORTS*RX_DEPTH)-1:0]    rx_addr,
   output logic [$clog2(PORTS*TX_DEPTH)-1:0]    tx_addr,
   output pend_type                             res
);
   localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int RXW = $clog2(RX_DEPTH);
   localparam int TXW = $clog2(TX_DEPTH);
   localparam int RXA = $clog2(PORTS*RX_DEPTH);
   localparam int TXA = $clog2(PORTS*TX_DEPTH);

   logic [RXW-1:0] rx_head_ff [PORTS];
   logic [RXW-1:0] rx_tail_ff [PORTS];
   logic [TXW-1:0] tx_head_ff [PORTS];
   logic [TXW-1:0] tx_tail_ff [PORTS];
   logic           tx_en_ff   [PORTS];

   logic [PW-1:0]  pidx;
   logic           in_range;
   logic [RXW-1:0] rh, rt, rh_in, rt_in, rxc;
   logic [TXW-1:0] th, tt, th_in, tt_in, txc;
   logic           en_in;
   logic [RXW:0]   rxd;
   logic [TXW:0]   txd;

   function automatic logic [RXW-1:0] rx_inc(input logic [RXW-1:0] p);
      return (p == RXW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] p);
      return (p == TXW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      pidx     = PW'(port);
      in_range = (32'(port) < PORTS);
      rh       = rx_head_ff[pidx];
      rt       = rx_tail_ff[pidx];
      th       = tx_head_ff[pidx];
      tt       = tx_tail_ff[pidx];
      rh_in    = rh;
      rt_in    = rt;
      th_in    = th;
      tt_in    = tt;
      en_in    = tx_en_ff[pidx];
      ctl      = '0;
      rx_addr  = RXA'(32'(pidx) * RX_DEPTH + 32'(rh));
      tx_addr  = TXA'(32'(pidx) * TX_DEPTH + 32'(th));
      res      = '0;
      unique case (op)
         OP_LINE_RX: begin
            ctl.rx_we = 1'b1;
            rh_in     = rx_inc(rh);
         end
         OP_HOST_READ: begin
            // stale byte at the tail is returned even when empty
            ctl.rx_re  = 1'b1;
            res.rd_sel = 1'b1;
            rx_addr    = RXA'(32'(pidx) * RX_DEPTH + 32'(rt));
            if (rh != rt) rt_in = rx_inc(rt);
         end
         OP_HOST_WRITE: begin
            // head moves first, byte lands at the new head
            th_in     = tx_inc(th);
            ctl.tx_we = 1'b1;
            tx_addr   = TXA'(32'(pidx) * TX_DEPTH + 32'(th_in));
            en_in     = 1'b1;
         end
         OP_TX_TICK: begin
            if (th != tt) begin
               tt_in        = tx_inc(tt);
               ctl.tx_re    = 1'b1;
               res.tx_valid = 1'b1;
               tx_addr      = TXA'(32'(pidx) * TX_DEPTH + 32'(tt_in));
            end
            if (tt_in == th) en_in = 1'b0;
         end
         default: ;
      endcase
      rxd = {1'b0, rh_in} - {1'b0, rt_in};
      txd = {1'b0, th_in} - {1'b0, tt_in};
      rxc = rxd[RXW] ? RXW'(rxd + (RXW+1)'(RX_DEPTH)) : RXW'(rxd);
      txc = txd[TXW] ? TXW'(txd + (TXW+1)'(TX_DEPTH)) : TXW'(txd);
      res.rx_count   = RXCNT_W'(rxc);
      res.tx_used    = TXUSED_W'(txc);
      res.tx_empty   = (th_in == tt_in);
      res.tx_enabled = en_in;
      if (!in_range) begin
         ctl = '0;
         res = '0;
      end
      if (!accept) ctl = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS; i++) begin
            rx_head_ff[i] <= '0;
            rx_tail_ff[i] <= '0;
            tx_head_ff[i] <= '0;
            tx_tail_ff[i] <= '0;
            tx_en_ff[i]   <= 1'b0;
         end
      end else if (accept && in_range) begin
         rx_head_ff[pidx] <= rh_in;
         rx_tail_ff[pidx] <= rt_in;
         tx_head_ff[pidx] <= th_in;
         tx_tail_ff[pidx] <= tt_in;
         tx_en_ff[pidx]   <= en_in;
      end
   end
endmodule

// ----- hdl/multi_port_serial_ring_buffers.sv -----
`timescale 1ns / 1ps
// Receive and transmit byte rings for PORTS serial ports, held in two single-port
// RAMs (PORTS*RX_DEPTH and PORTS*TX_DEPTH bytes) with the ring pointers and transmit
// enables in flip-flops. Each request costs at most one RAM access: pointers update and
// the RAM read data is registered at the accept edge, the response is registered from
// the pending stage after that, and one request is taken per cycle while the
// response side keeps up. While a response is stalled, one more request can enter the
// pending stage; after that, requests are blocked until the response is taken. Ring
// contents are not cleared at reset: a host read of an empty ring at a never-written
// entry returns an unspecified byte. Requests for a port at or above PORTS are ignored
// and answered with all fields zero.
`include "multi_port_serial_ring_buffers_macros.svh"
module multi_port_serial_ring_buffers import mpsrb_pkg::*; #(
   parameter int PORTS    = PORTS_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mpsrb_req_if.sink   req,
   mpsrb_rsp_if.source rsp
);
   localparam int RXA = $clog2(PORTS*RX_DEPTH);
   localparam int TXA = $clog2(PORTS*TX_DEPTH);

   mem_ctl_type       ctl;
   pend_type          res;
   logic [RXA-1:0]    rx_addr;
   logic [TXA-1:0]    tx_addr;
   logic [BYTE_W-1:0] rx_rdata, tx_rdata;
   logic              accept, out_free;

   logic              pend_valid_ff, pend_valid_in;
   pend_type          pend_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pend_type          out_ff;
   logic [BYTE_W-1:0] read_byte_ff, tx_byte_ff;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !pend_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   mpsrb_ctrl #(.PORTS(PORTS), .RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (req.op),
      .port    (req.port),
      .ctl     (ctl),
      .rx_addr (rx_addr),
      .tx_addr (tx_addr),
      .res     (res)
   );

   mpsrb_ram #(.WIDTH(BYTE_W), .DEPTH(PORTS*RX_DEPTH)) u_rx_ram (
      .clock (clock),
      .en    (ctl.rx_we || ctl.rx_re),
      .we    (ctl.rx_we),
      .addr  (rx_addr),
      .wdata (req.data_in),
      .rdata (rx_rdata)
   );

   mpsrb_ram #(.WIDTH(BYTE_W), .DEPTH(PORTS*TX_DEPTH)) u_tx_ram (
      .clock (clock),
      .en    (ctl.tx_we || ctl.tx_re),
      .we    (ctl.tx_we),
      .addr  (tx_addr),
      .wdata (req.data_in),
      .rdata (tx_rdata)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (pend_valid_ff && out_free) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
      end
      if (accept) pend_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // RAM read data stays put until the next accept, which is also when pend moves on
   always_ff @(posedge clock) begin
      if (accept) pend_ff <= res;
      if (pend_valid_ff && out_free) begin
         out_ff       <= pend_ff;
         read_byte_ff <= pend_ff.rd_sel   ? rx_rdata : '0;
         tx_byte_ff   <= pend_ff.tx_valid ? tx_rdata : '0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_byte  = read_byte_ff;
   assign rsp.rx_count   = out_ff.rx_count;
   assign rsp.tx_used    = out_ff.tx_used;
   assign rsp.tx_empty   = out_ff.tx_empty;
   assign rsp.tx_valid   = out_ff.tx_valid;
   assign rsp.tx_byte    = tx_byte_ff;
   assign rsp.tx_enabled = out_ff.tx_enabled;

   `MPSRB_ASSERT_NEXT(a_accept_pends, accept, pend_valid_ff, "accepted request not pending")
   `MPSRB_ASSERT(a_rx_one_access, !(ctl.rx_we && ctl.rx_re), "rx ram read and write together")
   `MPSRB_ASSERT(a_tx_one_access, !(ctl.tx_we && ctl.tx_re), "tx ram read and write together")
   `MPSRB_ASSERT_NEXT(a_pend_drains, pend_valid_ff && !rsp_valid_ff, rsp_valid_ff,
      "pending request not moved to response")
endmodule

// ----- verif/mpsrb_checker.sv -----
`timescale 1ns / 1ps
module mpsrb_checker import mpsrb_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   mpsrb_req_if  req_ch,
   mpsrb_rsp_if  rsp_ch,
   output int    mismatches,
   output int    queued
);

   localparam int RX_PTR_W = $clog2(RX_DEPTH_DEF);
   localparam int TX_PTR_W = $clog2(TX_DEPTH_DEF);

   typedef struct packed {
      logic [BYTE_W-1:0]   read_byte;
      logic [RXCNT_W-1:0]  rx_count;
      logic [TXUSED_W-1:0] tx_used;
      logic                tx_empty;
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_byte;
      logic                tx_enabled;
   } port_status_type;

   logic [BYTE_W-1:0]   rx_ring [PORTS_DEF][RX_DEPTH_DEF];
   logic [BYTE_W-1:0]   tx_ring [PORTS_DEF][TX_DEPTH_DEF];
   logic [RX_PTR_W-1:0] rx_wr_ptr [PORTS_DEF];
   logic [RX_PTR_W-1:0] rx_rd_ptr [PORTS_DEF];
   logic [TX_PTR_W-1:0] tx_wr_ptr [PORTS_DEF];
   logic [TX_PTR_W-1:0] tx_rd_ptr [PORTS_DEF];
   logic                tx_on     [PORTS_DEF];

   port_status_type status_q[$];
   port_status_type want;
   port_status_type seen;
   int              fail_count = 0;

   assign mismatches = fail_count;

   task automatic report_mismatch(input string what, input int got, input int wanted);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
      fail_count++;
   endtask

   // Updates the ring state for one request and returns the status it should produce.
   function automatic port_status_type apply_request(input logic [OP_W-1:0] op,
                                                     input logic [PORT_W-1:0] port,
                                                     input logic [BYTE_W-1:0] data);
      port_status_type st;
      st = '0;
      case (op)
         OP_LINE_RX: begin
            rx_ring[port][rx_wr_ptr[port]] = data;
            rx_wr_ptr[port] = rx_wr_ptr[port] + 1'b1;
         end
         OP_HOST_READ: begin
            // an empty ring still returns whatever sits at the tail
            st.read_byte = rx_ring[port][rx_rd_ptr[port]];
            if (rx_wr_ptr[port] != rx_rd_ptr[port])
               rx_rd_ptr[port] = rx_rd_ptr[port] + 1'b1;
         end
         OP_HOST_WRITE: begin
            tx_wr_ptr[port] = tx_wr_ptr[port] + 1'b1;
            tx_ring[port][tx_wr_ptr[port]] = data;
            tx_on[port] = 1'b1;
         end
         default: begin
            if (tx_wr_ptr[port] != tx_rd_ptr[port]) begin
               tx_rd_ptr[port] = tx_rd_ptr[port] + 1'b1;
               st.tx_byte  = tx_ring[port][tx_rd_ptr[port]];
               st.tx_valid = 1'b1;
            end
            if (tx_rd_ptr[port] == tx_wr_ptr[port])
               tx_on[port] = 1'b0;
         end
      endcase
      st.rx_count   = RXCNT_W'(rx_wr_ptr[port] - rx_rd_ptr[port]);
      st.tx_used    = TXUSED_W'(tx_wr_ptr[port] - tx_rd_ptr[port]);
      st.tx_empty   = (tx_wr_ptr[port] == tx_rd_ptr[port]);
      st.tx_enabled = tx_on[port];
      return st;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS_DEF; i++) begin
            rx_wr_ptr[i] = '0;
            rx_rd_ptr[i] = '0;
            tx_wr_ptr[i] = '0;
            tx_rd_ptr[i] = '0;
            tx_on[i]     = 1'b0;
         end
         status_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            status_q.push_back(apply_request(req_ch.op, req_ch.port, req_ch.data_in));
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_byte  = rsp_ch.read_byte;
            seen.rx_count   = rsp_ch.rx_count;
            seen.tx_used    = rsp_ch.tx_used;
            seen.tx_empty   = rsp_ch.tx_empty;
            seen.tx_valid   = rsp_ch.tx_valid;
            seen.tx_byte    = rsp_ch.tx_byte;
            seen.tx_enabled = rsp_ch.tx_enabled;
            if (status_q.size() == 0) begin
               report_mismatch("response with no request outstanding", int'(seen), 0);
            end else begin
               want = status_q.pop_front();
               if (seen.read_byte !== want.read_byte)
                  report_mismatch("read_byte", int'(seen.read_byte), int'(want.read_byte));
               if (seen.rx_count !== want.rx_count)
                  report_mismatch("rx_count", int'(seen.rx_count), int'(want.rx_count));
               if (seen.tx_used !== want.tx_used)
                  report_mismatch("tx_used", int'(seen.tx_used), int'(want.tx_used));
               if (seen.tx_empty !== want.tx_empty)
                  report_mismatch("tx_empty", int'(seen.tx_empty), int'(want.tx_empty));
               if (seen.tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", int'(seen.tx_valid), int'(want.tx_valid));
               if (seen.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", int'(seen.tx_byte), int'(want.tx_byte));
               if (seen.tx_enabled !== want.tx_enabled)
                  report_mismatch("tx_enabled", int'(seen.tx_enabled),
                                  int'(want.tx_enabled));
            end
         end
      end
      queued <= status_q.size();
   end

endmodule

// ----- verif/multi_port_serial_ring_buffers_test.sv -----
`timescale 1ns / 1ps
module multi_port_serial_ring_buffers_test;
   import mpsrb_pkg::*;

   localparam int RX_PTR_W = $clog2(RX_DEPTH_DEF);
   localparam int TX_PTR_W = $clog2(TX_DEPTH_DEF);
   localparam int TARGET_REQS = 1150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   queued;

   mpsrb_req_if req_ch ();
   mpsrb_rsp_if rsp_ch ();

   multi_port_serial_ring_buffers u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   mpsrb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .queued     (queued)
   );

   // pointer shadow: steers stimulus away from never-written receive entries and counts wraps and empty accesses
   logic [RX_PTR_W-1:0] rx_in_ptr  [PORTS_DEF];
   logic [RX_PTR_W-1:0] rx_out_ptr [PORTS_DEF];
   bit                  rx_touched [PORTS_DEF][RX_DEPTH_DEF];
   logic [TX_PTR_W-1:0] tx_in_ptr  [PORTS_DEF];
   logic [TX_PTR_W-1:0] tx_out_ptr [PORTS_DEF];

   int n_sent = 0;
   int n_stale_reads = 0;
   int n_rx_wraps = 0;
   int n_tx_wraps = 0;
   int n_idle_ticks = 0;
   int n_drains = 0;
   bit sender_steady = 1'b0;

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #4_000_000;
      $display("[multi_port_serial_ring_buffers] ERROR");
      $finish;
   end

   task automatic issue(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                        input logic [BYTE_W-1:0] data);
      logic [OP_W-1:0] use_op;
      int              gap;
      use_op = op;
      // empty read at an entry nobody ever wrote: send a line byte instead
      if (op == OP_HOST_READ && rx_in_ptr[port] == rx_out_ptr[port] &&
          !rx_touched[port][rx_out_ptr[port]])
         use_op = OP_LINE_RX;
      case (use_op)
         OP_LINE_RX: begin
            rx_touched[port][rx_in_ptr[port]] = 1'b1;
            rx_in_ptr[port] = rx_in_ptr[port] + 1'b1;
            if (rx_in_ptr[port] == rx_out_ptr[port])
               n_rx_wraps++;
         end
         OP_HOST_READ: begin
            if (rx_in_ptr[port] != rx_out_ptr[port])
               rx_out_ptr[port] = rx_out_ptr[port] + 1'b1;
            else
               n_stale_reads++;
         end
         OP_HOST_WRITE: begin
            tx_in_ptr[port] = tx_in_ptr[port] + 1'b1;
            if (tx_in_ptr[port] == tx_out_ptr[port])
               n_tx_wraps++;
         end
         default: begin
            if (tx_in_ptr[port] != tx_out_ptr[port])
               tx_out_ptr[port] = tx_out_ptr[port] + 1'b1;
            else
               n_idle_ticks++;
         end
      endcase
      gap = sender_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= use_op;
      req_ch.port    <= port;
      req_ch.data_in <= data;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      n_sent++;
   endtask

   // hold off new requests until every response is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (queued != 0);
      n_drains++;
   endtask

   // response side: random stalls, with stretches of none
   initial begin
      int  stall;
      int  taken;
      bit  sink_steady;
      taken = 0;
      sink_steady = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0)
            sink_steady = ($urandom_range(0, 3) == 0);
         taken++;
         stall = sink_steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      logic [PORT_W-1:0] p;
      int                k;
      for (int i = 0; i < PORTS_DEF; i++) begin
         rx_in_ptr[i]  = '0;
         rx_out_ptr[i] = '0;
         tx_in_ptr[i]  = '0;
         tx_out_ptr[i] = '0;
      end
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_LINE_RX;
      req_ch.port    <= '0;
      req_ch.data_in <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: every op, byte extremes, tick on an empty ring
      issue(OP_TX_TICK,    2'd0, 8'h00);
      issue(OP_LINE_RX,    2'd0, 8'h00);
      issue(OP_LINE_RX,    2'd0, 8'hFF);
      issue(OP_HOST_READ,  2'd0, 8'hFF);
      issue(OP_HOST_READ,  2'd0, 8'h00);
      issue(OP_HOST_WRITE, 2'd1, 8'hAA);
      issue(OP_HOST_WRITE, 2'd1, 8'h55);
      issue(OP_TX_TICK,    2'd1, 8'hFF);
      issue(OP_TX_TICK,    2'd1, 8'h00);
      issue(OP_TX_TICK,    2'd1, 8'h00);
      issue(OP_HOST_WRITE, 2'd2, 8'hFF);
      issue(OP_HOST_WRITE, 2'd3, 8'h00);
      issue(OP_LINE_RX,    2'd1, 8'h80);
      issue(OP_LINE_RX,    2'd2, 8'h01);
      issue(OP_LINE_RX,    2'd3, 8'h7F);
      issue(OP_HOST_READ,  2'd1, 8'h00);
      issue(OP_HOST_READ,  2'd2, 8'h00);
      issue(OP_HOST_READ,  2'd3, 8'h00);
      issue(OP_TX_TICK,    2'd2, 8'h00);
      issue(OP_TX_TICK,    2'd3, 8'h00);
      drain();

      // receive overrun until the ring looks empty, then a stale read
      do issue(OP_LINE_RX, 2'd3, 8'($urandom_range(0, 255)));
      while (rx_in_ptr[3] != rx_out_ptr[3]);
      issue(OP_HOST_READ, 2'd3, 8'($urandom_range(0, 255)));
      // transmit overrun: enable stays set until the next tick finds nothing
      do issue(OP_HOST_WRITE, 2'd2, 8'($urandom_range(0, 255)));
      while (tx_in_ptr[2] != tx_out_ptr[2]);
      issue(OP_TX_TICK, 2'd2, 8'h00);
      issue(OP_HOST_WRITE, 2'd2, 8'($urandom_range(0, 255)));
      issue(OP_TX_TICK, 2'd2, 8'h00);
      drain();

      while (n_sent < TARGET_REQS) begin
         p = PORT_W'($urandom_range(0, PORTS_DEF - 1));
         sender_steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               k = $urandom_range(1, 12);
               repeat (k) issue(OP_LINE_RX, p, 8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, k + 2))
                  issue(OP_HOST_READ, p, 8'($urandom_range(0, 255)));
            end
            3, 4, 5: begin
               k = $urandom_range(1, 12);
               repeat (k) issue(OP_HOST_WRITE, p, 8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, k + 2))
                  issue(OP_TX_TICK, p, 8'($urandom_range(0, 255)));
            end
            6, 7: begin
               repeat (8)
                  issue(OP_W'($urandom_range(0, 3)), PORT_W'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255)));
            end
            8: begin
               if ($urandom_range(0, 7) == 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     do issue(OP_LINE_RX, p, 8'($urandom_range(0, 255)));
                     while (rx_in_ptr[p] != rx_out_ptr[p]);
                  end else begin
                     do issue(OP_HOST_WRITE, p, 8'($urandom_range(0, 255)));
                     while (tx_in_ptr[p] != tx_out_ptr[p]);
                  end
               end else begin
                  repeat (10)
                     issue(OP_W'($urandom_range(0, 3)), p, 8'($urandom_range(0, 255)));
               end
            end
            default: begin
               drain();
               issue(OP_W'($urandom_range(0, 3)), p, 8'($urandom_range(0, 255)));
            end
         endcase
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (queued != 0);
      repeat (10) @(posedge clock);

      $display("%0d requests sent: %0d empty host reads, %0d empty ticks", n_sent,
               n_stale_reads, n_idle_ticks);
      $display("%0d receive wraps, %0d transmit wraps, %0d full drains", n_rx_wraps,
               n_tx_wraps, n_drains);
      if (mismatches == 0) begin
         $display("[multi_port_serial_ring_buffers] OK");
      end else begin
         $display("[multi_port_serial_ring_buffers] ERROR");
      end
      $finish;
   end

endmodule
